FILE: rtl/core/vqbd_pkg.sv
// vqbd_pkg: shared types, codes and sizes for the vq block decoder
// no dependencies; imported by vq_block_decoder_core
package vqbd_pkg;

  // default sizes
  localparam int DEF_CODEBOOK_WORDS     = 65536;
  localparam int DEF_MAX_BLOCKS_PER_ROW = 256;

  // width of a codebook word address before range check (8 * 16-bit pointer + 7)
  localparam int ENTRY_AW = 19;

  localparam int CB_WORD_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS     = 2'd2;

  // pixel formats
  localparam logic [1:0] FMT_8BIT_4X2  = 2'd0;
  localparam logic [1:0] FMT_8BIT_4X4  = 2'd1;
  localparam logic [1:0] FMT_8BIT_HALF = 2'd2;
  localparam logic [1:0] FMT_16BIT_4X4 = 2'd3;

  // input beat kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // register reset values
  localparam logic [1:0]            RST_PIXEL_FORMAT   = FMT_8BIT_4X4;
  localparam logic [CFG_DATA_W-1:0] RST_BLOCKS_PER_ROW = 9'd160;
  localparam logic [CFG_DATA_W-1:0] RST_BLOCK_ROWS     = 9'd100;

  localparam logic [7:0] SOLID_HIGH = 8'hFF;

  typedef struct packed {
    logic        mode;
    logic [15:0] load_address;
    logic [31:0] load_data;
    logic [7:0]  index_low;
    logic [7:0]  index_high;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic [1:0]  row_in_block;
    logic [7:0]  block_column;
    logic [7:0]  block_line;
    logic        last_row;
    logic        frame_end;
    logic        out_of_range;
  } out_beat_t;

endpackage

FILE: rtl/core/vq_block_decoder_core.sv
// vq_block_decoder_core: codebook store plus block pointer decode to pixel rows
// depends on vqbd_pkg and vqbd_ram
//
//   channel  | signals                                   | beat
//   ---------+-------------------------------------------+-------------------------------
//   cfg      | cfg_write, cfg_index, cfg_data            | one register write per cycle
//   in       | in_valid, in_stall, in_data (in_beat_t)   | codebook load or block pointer
//   out      | out_valid, out_stall, out_data            | one pixel row of a block
//
// a pointer emits one row per codebook ram read: 4 in 4x4 and 16-bit modes, 2 in 4x2
// and half size (both read ports in 16-bit mode). each row passes the issue stage,
// the data stage with the ram read, and the output register.
// reset clears counters, registers and valid flags; the codebook holds no reset.
// a stall on out holds the row pipeline in place; loads wait until a pointer's reads issue.
module vq_block_decoder_core
  import vqbd_pkg::*;
#(
  parameter int CODEBOOK_WORDS     = DEF_CODEBOOK_WORDS,
  parameter int MAX_BLOCKS_PER_ROW = DEF_MAX_BLOCKS_PER_ROW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data
);

  localparam int CB_AW  = $clog2(CODEBOOK_WORDS);
  localparam int CMP_W  = ENTRY_AW + 1;
  localparam int CW     = $clog2(MAX_BLOCKS_PER_ROW);
  localparam int BPR_W  = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

  // configuration registers
  logic [1:0]            pixel_format;
  logic [CFG_DATA_W-1:0] blocks_per_row;
  logic [CFG_DATA_W-1:0] block_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= RST_PIXEL_FORMAT;
      blocks_per_row <= RST_BLOCKS_PER_ROW;
      block_rows     <= RST_BLOCK_ROWS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT:   pixel_format   <= cfg_data[1:0];
        REG_BLOCKS_PER_ROW: blocks_per_row <= cfg_data;
        REG_BLOCK_ROWS:     block_rows     <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position counters
  logic [CW-1:0]          column_count;
  logic [7:0]             line_count;
  logic [BPR_W-1:0]       bpr_eff;
  logic [CFG_DATA_W-1:0]  nrows_eff;
  logic                   last_col;
  logic                   frame_last;

  always_comb begin
    if (blocks_per_row == '0) begin
      bpr_eff = BPR_W'(1);
    end else if (BPR_W'(blocks_per_row) > BPR_W'(MAX_BLOCKS_PER_ROW)) begin
      bpr_eff = BPR_W'(MAX_BLOCKS_PER_ROW);
    end else begin
      bpr_eff = BPR_W'(blocks_per_row);
    end
    if (block_rows == '0) begin
      nrows_eff = CFG_DATA_W'(1);
    end else if (block_rows > CFG_DATA_W'(256)) begin
      nrows_eff = CFG_DATA_W'(256);
    end else begin
      nrows_eff = block_rows;
    end
    last_col   = (BPR_W'(column_count) + BPR_W'(1)) >= bpr_eff;
    frame_last = last_col && ((CFG_DATA_W'(line_count) + CFG_DATA_W'(1)) >= nrows_eff);
  end

  // handshake and pipeline control
  logic out_free;
  logic s2_valid;
  logic s2_free;
  logic s2_adv;
  logic busy;
  logic issue;
  logic last_issue;
  logic in_accept;
  logic dec_accept;
  logic [1:0] row;
  logic [1:0] row_last;

  assign out_free   = !out_valid || !out_stall;
  assign s2_adv     = s2_valid && out_free;
  assign s2_free    = !s2_valid || out_free;
  assign issue      = busy && s2_free;
  assign last_issue = issue && (row == row_last);
  assign in_stall   = busy && !last_issue;
  assign in_accept  = in_valid && !in_stall;
  assign dec_accept = in_accept && (in_data.mode == MODE_DECODE);

  // pointer decode at accept
  logic [15:0]         idx;
  logic                solid_in;
  logic [ENTRY_AW-1:0] base_in;
  logic [ENTRY_AW-1:0] entry_end;
  logic                bad_in;

  always_comb begin
    idx = {in_data.index_high, in_data.index_low};
    unique case (pixel_format)
      FMT_8BIT_4X2: begin
        solid_in  = (in_data.index_high == SOLID_HIGH);
        base_in   = ENTRY_AW'({idx, 1'b0});
        entry_end = ENTRY_AW'({idx, 1'b1});
      end
      FMT_8BIT_4X4: begin
        solid_in  = (in_data.index_high == SOLID_HIGH);
        base_in   = ENTRY_AW'({idx, 2'b00});
        entry_end = ENTRY_AW'({idx, 2'b11});
      end
      FMT_8BIT_HALF: begin
        solid_in  = (in_data.index_high == SOLID_HIGH);
        base_in   = ENTRY_AW'({idx, 2'b00});
        entry_end = ENTRY_AW'({idx, 2'b10});
      end
      default: begin
        solid_in  = idx[15];
        base_in   = {idx, 3'b000};
        entry_end = {idx, 3'b111};
      end
    endcase
    bad_in = !solid_in && (CMP_W'(entry_end) >= CMP_W'(CODEBOOK_WORDS));
  end

  // issue stage: one row read per cycle while the data stage can take it
  logic [1:0]          s1_fmt;
  logic                s1_solid;
  logic                s1_bad;
  logic [14:0]         s1_color;
  logic [ENTRY_AW-1:0] s1_addr;
  logic [7:0]          s1_col;
  logic [7:0]          s1_line;
  logic                s1_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      column_count <= '0;
      line_count   <= '0;
    end else begin
      if (issue) begin
        row <= row + 2'd1;
        if ((s1_fmt == FMT_8BIT_HALF) || (s1_fmt == FMT_16BIT_4X4)) begin
          s1_addr <= s1_addr + ENTRY_AW'(2);
        end else begin
          s1_addr <= s1_addr + ENTRY_AW'(1);
        end
        if (last_issue) begin
          busy <= 1'b0;
        end
      end
      if (dec_accept) begin
        busy     <= 1'b1;
        row      <= 2'd0;
        row_last <= ((pixel_format == FMT_8BIT_4X2) || (pixel_format == FMT_8BIT_HALF))
                    ? 2'd1 : 2'd3;
        s1_fmt   <= pixel_format;
        s1_solid <= solid_in;
        s1_bad   <= bad_in;
        s1_color <= idx[14:0];
        s1_addr  <= base_in;
        s1_col   <= 8'(column_count);
        s1_line  <= line_count;
        s1_fend  <= frame_last;
        if (frame_last) begin
          column_count <= '0;
          line_count   <= '0;
        end else if (last_col) begin
          column_count <= '0;
          line_count   <= line_count + 8'd1;
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  // codebook store
  logic                 load_we;
  logic [CB_WORD_W-1:0] rd_a;
  logic [CB_WORD_W-1:0] rd_b;

  assign load_we = in_accept && (in_data.mode == MODE_LOAD)
                   && (CMP_W'(in_data.load_address) < CMP_W'(CODEBOOK_WORDS));

  vqbd_ram #(
    .WIDTH (CB_WORD_W),
    .DEPTH (CODEBOOK_WORDS)
  ) u_codebook (
    .clk     (clk),
    .we      (load_we),
    .waddr   (CB_AW'(in_data.load_address)),
    .wdata   (in_data.load_data),
    .re      (issue),
    .raddr_a (CB_AW'(s1_addr)),
    .raddr_b (CB_AW'(s1_addr | ENTRY_AW'(1))),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // data stage: ram output plus row tags
  logic [1:0]  s2_row;
  logic        s2_last;
  logic [1:0]  s2_fmt;
  logic        s2_solid;
  logic        s2_bad;
  logic [14:0] s2_color;
  logic [7:0]  s2_col;
  logic [7:0]  s2_line;
  logic        s2_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (issue) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
    if (issue) begin
      s2_row   <= row;
      s2_last  <= (row == row_last);
      s2_fmt   <= s1_fmt;
      s2_solid <= s1_solid;
      s2_bad   <= s1_bad;
      s2_color <= s1_color;
      s2_col   <= s1_col;
      s2_line  <= s1_line;
      s2_fend  <= s1_fend;
    end
  end

  // row formatting
  out_beat_t row_beat;

  always_comb begin
    row_beat.row_pixels = '0;
    if (s2_bad) begin
      row_beat.row_pixels = '0;
    end else if (s2_solid) begin
      case (s2_fmt)
        FMT_8BIT_HALF: row_beat.row_pixels = {48'd0, {2{s2_color[7:0]}}};
        FMT_16BIT_4X4: row_beat.row_pixels = {4{1'b0, s2_color}};
        default:       row_beat.row_pixels = {32'd0, {4{s2_color[7:0]}}};
      endcase
    end else begin
      case (s2_fmt)
        FMT_8BIT_HALF: row_beat.row_pixels = {48'd0, rd_a[23:16], rd_a[7:0]};
        FMT_16BIT_4X4: row_beat.row_pixels = {rd_b, rd_a};
        default:       row_beat.row_pixels = {32'd0, rd_a};
      endcase
    end
    row_beat.row_in_block = s2_row;
    row_beat.block_column = s2_col;
    row_beat.block_line   = s2_line;
    row_beat.last_row     = s2_last;
    row_beat.frame_end    = s2_fend;
    row_beat.out_of_range = s2_bad;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s2_adv) begin
      out_data <= row_beat;
    end
  end

endmodule

FILE: rtl/core/vqbd_ram.sv
// vqbd_ram: generic ram, one write port and two read ports, registered read
// read-first on a same-address write; no dependencies
module vqbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: test/vq_block_decoder_core_test.sv
// vq_block_decoder_core_test: self-checking bench for the vq block decoder core
// depends on vqbd_pkg and vq_block_decoder_core; directed table, then random phases
// checked against a behavioral model of codebook, pixel rows and frame counters
module vq_block_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vqbd_pkg::*;

  localparam int unsigned CB_WORDS       = DEF_CODEBOOK_WORDS;
  localparam int unsigned MAX_ROW_BLOCKS = DEF_MAX_BLOCKS_PER_ROW;
  localparam int unsigned MAX_FRAME_ROWS = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASE_BEATS   = 50;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_PTR} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [15:0] a;      // register index, load address or block pointer
    logic [31:0] d;      // register value or load data
    logic        typed;
    logic [63:0] pix;
    logic        oor;
  } step_t;

  typedef struct packed {
    logic [1:0]            fmt;
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] rows;
    int                    idle;
    int                    stall;
    logic                  squeeze;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;

  // model state
  logic [31:0]           cb_image [int unsigned];
  logic [1:0]            cur_fmt = RST_PIXEL_FORMAT;
  logic [CFG_DATA_W-1:0] row_width = RST_BLOCKS_PER_ROW;
  logic [CFG_DATA_W-1:0] frame_height = RST_BLOCK_ROWS;
  int unsigned           col_pos = 0;
  int unsigned           line_pos = 0;
  logic                  fetch_bad;

  out_beat_t   expected_rows [$];
  out_beat_t   want_row;
  int unsigned ready_ptrs [0:3][$];
  int          rows_predicted = 0;
  int          beats_sent = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;

  step_t dir_steps [24] = '{
    '{STEP_LOAD, 16'h0000, 32'h0403_0201, 1'b0, 64'h0, 1'b0},
    '{STEP_LOAD, 16'h0001, 32'h0807_0605, 1'b0, 64'h0, 1'b0},
    '{STEP_LOAD, 16'h0002, 32'h0C0B_0A09, 1'b0, 64'h0, 1'b0},
    '{STEP_LOAD, 16'h0003, 32'h100F_0E0D, 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'h0000, 32'h0, 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'hFFA5, 32'h0, 1'b1, 64'h0000_0000_A5A5_A5A5, 1'b0},
    '{STEP_PTR,  16'h4000, 32'h0, 1'b1, 64'h0, 1'b1},
    '{STEP_PTR,  16'hFEFF, 32'h0, 1'b1, 64'h0, 1'b1},
    '{STEP_CFG,  16'(REG_PIXEL_FORMAT), 32'(FMT_8BIT_4X2), 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'h0001, 32'h0, 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'hFF00, 32'h0, 1'b1, 64'h0, 1'b0},
    '{STEP_PTR,  16'h8000, 32'h0, 1'b1, 64'h0, 1'b1},
    '{STEP_LOAD, 16'hFFFE, 32'h0000_0000, 1'b0, 64'h0, 1'b0},
    '{STEP_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'h7FFF, 32'h0, 1'b0, 64'h0, 1'b0},
    '{STEP_CFG,  16'(REG_PIXEL_FORMAT), 32'(FMT_8BIT_HALF), 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'h0000, 32'h0, 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'hFFFF, 32'h0, 1'b1, 64'h0000_0000_0000_FFFF, 1'b0},
    '{STEP_PTR,  16'h4000, 32'h0, 1'b1, 64'h0, 1'b1},
    '{STEP_CFG,  16'(REG_PIXEL_FORMAT), 32'(FMT_16BIT_4X4), 1'b0, 64'h0, 1'b0},
    '{STEP_PTR,  16'hFFFF, 32'h0, 1'b1, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0},
    '{STEP_PTR,  16'h8000, 32'h0, 1'b1, 64'h0, 1'b0},
    '{STEP_PTR,  16'h2000, 32'h0, 1'b1, 64'h0, 1'b1},
    '{STEP_PTR,  16'h7FFF, 32'h0, 1'b1, 64'h0, 1'b1}
  };

  phase_t phases [8] = '{
    '{FMT_8BIT_4X2,  9'd1,   9'd1,   0,  0,  1'b0},
    '{FMT_8BIT_4X4,  9'd3,   9'd2,   63, 0,  1'b0},
    '{FMT_8BIT_HALF, 9'd0,   9'd0,   0,  63, 1'b0},
    '{FMT_16BIT_4X4, 9'd5,   9'd3,   29, 29, 1'b0},
    '{FMT_8BIT_4X4,  9'd256, 9'd256, 0,  0,  1'b1},
    '{FMT_8BIT_4X2,  9'd511, 9'd511, 29, 29, 1'b0},
    '{FMT_16BIT_4X4, 9'd2,   9'd511, 0,  63, 1'b0},
    '{FMT_8BIT_HALF, 9'd7,   9'd1,   63, 0,  1'b0}
  };

  vq_block_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned entry_stride(input logic [1:0] f);
    case (f)
      FMT_8BIT_4X2:  return 2;
      FMT_16BIT_4X4: return 8;
      default:       return 4;
    endcase
  endfunction

  function automatic logic [31:0] cb_word(input int unsigned addr);
    if (addr >= CB_WORDS) begin
      fetch_bad = 1'b1;
      return '0;
    end
    if (!cb_image.exists(addr)) return '0;
    return cb_image[addr];
  endfunction

  // updates codebook and counters, queues the rows a beat causes
  function automatic int predict_rows(input in_beat_t b);
    logic [15:0] ptr;
    logic [31:0] word;
    logic [63:0] pix [4];
    logic        solid, last_col, fend;
    int unsigned base, w, h;
    int          n;
    out_beat_t   r;
    if (b.mode == MODE_LOAD) begin
      cb_image[b.load_address] = b.load_data;
      return 0;
    end
    ptr = {b.index_high, b.index_low};
    fetch_bad = 1'b0;
    base = ptr * entry_stride(cur_fmt);
    n = (cur_fmt == FMT_8BIT_4X2 || cur_fmt == FMT_8BIT_HALF) ? 2 : 4;
    solid = (cur_fmt == FMT_16BIT_4X4) ? ptr[15] : (b.index_high == SOLID_HIGH);
    for (int k = 0; k < n; k++) begin
      case (cur_fmt)
        FMT_8BIT_HALF: begin
          word = solid ? {2{8'h0, b.index_low}} : cb_word(base + 2 * k);
          pix[k] = {48'h0, word[23:16], word[7:0]};
        end
        FMT_16BIT_4X4:
          pix[k] = solid ? {4{1'b0, ptr[14:0]}}
                         : {cb_word(base + 2 * k + 1), cb_word(base + 2 * k)};
        default:
          pix[k] = solid ? {32'h0, {4{b.index_low}}} : {32'h0, cb_word(base + k)};
      endcase
    end
    w = (row_width == 0) ? 1 : ((row_width > MAX_ROW_BLOCKS) ? MAX_ROW_BLOCKS : row_width);
    h = (frame_height == 0) ? 1
        : ((frame_height > MAX_FRAME_ROWS) ? MAX_FRAME_ROWS : frame_height);
    last_col = (col_pos + 1 >= w);
    fend = last_col && (line_pos + 1 >= h);
    for (int k = 0; k < n; k++) begin
      r.row_pixels   = fetch_bad ? 64'h0 : pix[k];
      r.row_in_block = k[1:0];
      r.block_column = col_pos[7:0];
      r.block_line   = line_pos[7:0];
      r.last_row     = (k == n - 1);
      r.frame_end    = fend;
      r.out_of_range = fetch_bad;
      expected_rows.push_back(r);
    end
    if (fend) begin
      col_pos = 0;
      line_pos = 0;
    end else if (last_col) begin
      col_pos = 0;
      line_pos = (line_pos + 1) & 16'hFFFF;
    end else begin
      col_pos = (col_pos + 1) & 16'hFFFF;
    end
    return n;
  endfunction

  function automatic in_beat_t load_beat(input logic [15:0] addr, input logic [31:0] data);
    in_beat_t b;
    b.mode = MODE_LOAD;
    b.load_address = addr;
    b.load_data = data;
    b.index_low = 8'($urandom);
    b.index_high = 8'($urandom);
    return b;
  endfunction

  function automatic in_beat_t ptr_beat(input logic [15:0] ptr);
    in_beat_t b;
    b.mode = MODE_DECODE;
    b.load_address = 16'($urandom);
    b.load_data = $urandom;
    b.index_low = ptr[7:0];
    b.index_high = ptr[15:8];
    return b;
  endfunction

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t  %s", $time, what);
  endtask

  // leaves valid high on return so back-to-back beats need no second assignment
  task automatic send(input in_beat_t b);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    rows_predicted = predict_rows(b);
    beats_sent++;
  endtask

  // waits out every row, then lets a trailing load settle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      REG_PIXEL_FORMAT:   cur_fmt = val[1:0];
      REG_BLOCKS_PER_ROW: row_width = val;
      REG_BLOCK_ROWS:     frame_height = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // typed-in expectation replaces the pixels and flag of the rows just queued
  task automatic stamp_rows(input logic [63:0] pix, input logic oor);
    out_beat_t t;
    for (int k = 1; k <= rows_predicted; k++) begin
      t = expected_rows[expected_rows.size() - k];
      t.row_pixels = pix;
      t.out_of_range = oor;
      expected_rows[expected_rows.size() - k] = t;
    end
  endtask

  task automatic random_item();
    int unsigned span, pick, idx, stride;
    stride = entry_stride(cur_fmt);
    span = CB_WORDS / stride;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // fill an entry with fresh words, then decode it
      idx = $urandom_range(span - 1);
      for (int k = 0; k < stride; k++) send(load_beat(16'(idx * stride + k), $urandom));
      ready_ptrs[cur_fmt].push_back(idx);
      send(ptr_beat(16'(idx)));
    end else if (pick < 68 && ready_ptrs[cur_fmt].size() != 0) begin
      idx = ready_ptrs[cur_fmt][$urandom_range(ready_ptrs[cur_fmt].size() - 1)];
      send(ptr_beat(16'(idx)));
    end else if (pick < 80) begin
      if (cur_fmt == FMT_16BIT_4X4) idx = 32'h8000 | $urandom_range(32'h7FFF);
      else idx = {SOLID_HIGH, 8'($urandom)};
      send(ptr_beat(16'(idx)));
    end else if (pick < 90) begin
      // entry past the end of the store, solid pointers excluded
      idx = $urandom_range((cur_fmt == FMT_16BIT_4X4) ? 32'h7FFF : 32'hFEFF, span);
      send(ptr_beat(16'(idx)));
    end else begin
      send(load_beat(16'($urandom), $urandom));
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("vq_block_decoder_core test failed");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_rows.size() == 0) begin
        flag($sformatf("row beat with nothing expected: %h", out_data));
      end else begin
        want_row = expected_rows.pop_front();
        if (out_data.row_pixels !== want_row.row_pixels ||
            out_data.row_in_block !== want_row.row_in_block ||
            out_data.block_column !== want_row.block_column ||
            out_data.block_line !== want_row.block_line ||
            out_data.last_row !== want_row.last_row ||
            out_data.frame_end !== want_row.frame_end ||
            out_data.out_of_range !== want_row.out_of_range)
          flag($sformatf({"row mismatch: exp pix %h row %0d col %0d line %0d last %b end %b ",
                          "oor %b / got pix %h row %0d col %0d line %0d last %b end %b oor %b"},
                         want_row.row_pixels, want_row.row_in_block, want_row.block_column,
                         want_row.block_line, want_row.last_row, want_row.frame_end,
                         want_row.out_of_range, out_data.row_pixels, out_data.row_in_block,
                         out_data.block_column, out_data.block_line, out_data.last_row,
                         out_data.frame_end, out_data.out_of_range));
      end
    end
  end

  initial begin : stimulus
    int unsigned stop_at;
    logic [6:0]  junk;
    logic        squeezed;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      case (dir_steps[i].kind)
        STEP_CFG: begin
          quiesce();
          set_reg(dir_steps[i].a[CFG_IDX_W-1:0], dir_steps[i].d[CFG_DATA_W-1:0]);
        end
        STEP_LOAD: send(load_beat(dir_steps[i].a, dir_steps[i].d));
        default: begin
          send(ptr_beat(dir_steps[i].a));
          if (dir_steps[i].typed) stamp_rows(dir_steps[i].pix, dir_steps[i].oor);
        end
      endcase
    end

    foreach (phases[p]) begin
      quiesce();
      junk = 7'($urandom);
      set_reg(REG_PIXEL_FORMAT, {junk, phases[p].fmt});
      set_reg(REG_BLOCKS_PER_ROW, phases[p].width);
      set_reg(REG_BLOCK_ROWS, phases[p].rows);
      idle_pct = phases[p].idle;
      stall_pct = phases[p].stall;
      stop_at = beats_sent + PHASE_BEATS;
      squeezed = 1'b0;
      while (beats_sent < stop_at) begin
        // long hold on the output while beats keep coming, so the core backs up
        if (phases[p].squeeze && !squeezed && beats_sent + 40 >= stop_at) begin
          hold_request = HOLD_CYCLES;
          squeezed = 1'b1;
        end
        random_item();
      end
    end

    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("vq_block_decoder_core test passed");
    end else begin
      $display("vq_block_decoder_core test failed");
    end
    $finish;
  end

endmodule
